[rtl/phc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package phc_pkg;
    localparam int unsigned MaxFrameBytes = 16383;
    localparam int unsigned LenW = 14;

    localparam logic [15:0] EtVlan = 16'h8100;
    localparam logic [15:0] EtQinq = 16'h88A8;
    localparam logic [15:0] EtIpv4 = 16'h0800;
    localparam logic [15:0] EtIpv6 = 16'h86DD;
    localparam logic [15:0] EtArp  = 16'h0806;
    localparam logic [7:0]  ProtoIcmp  = 8'd1;
    localparam logic [7:0]  ProtoTcp   = 8'd6;
    localparam logic [7:0]  ProtoUdp   = 8'd17;
    localparam logic [7:0]  ProtoIcmp6 = 8'd58;

    localparam logic [2:0] CfgHttps   = 3'd0;
    localparam logic [2:0] CfgHttp    = 3'd1;
    localparam logic [2:0] CfgHttpAlt = 3'd2;
    localparam logic [2:0] CfgDns     = 3'd3;
    localparam logic [2:0] CfgMdns    = 3'd4;

    localparam logic [3:0] ClsUnknown = 4'd0;
    localparam logic [3:0] ClsArp     = 4'd1;
    localparam logic [3:0] ClsTcp     = 4'd2;
    localparam logic [3:0] ClsHttps   = 4'd3;
    localparam logic [3:0] ClsHttp    = 4'd4;
    localparam logic [3:0] ClsUdp     = 4'd5;
    localparam logic [3:0] ClsQuic    = 4'd6;
    localparam logic [3:0] ClsDns     = 4'd7;
    localparam logic [3:0] ClsIcmp    = 4'd8;

    localparam logic [1:0] KindNone = 2'd0;
    localparam logic [1:0] KindTcp  = 2'd1;
    localparam logic [1:0] KindUdp  = 2'd2;
    localparam logic [1:0] KindIcmp = 2'd3;

    typedef struct packed {
        logic [15:0] https;
        logic [15:0] http;
        logic [15:0] http_alt;
        logic [15:0] dns;
        logic [15:0] mdns;
    } t_ports;

    typedef struct packed {
        logic [15:0] outer_et;
        logic [15:0] inner_et;
        logic [6:0]  ip_hdr;
        logic [7:0]  proto;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  flags;
        logic [6:0]  tcp_hdr;
        logic [55:0] prefix;
    } t_hdr;

    typedef struct packed {
        logic [3:0]  protocol_class;
        logic [1:0]  ip_version;
        logic        vlan_tagged;
        logic [7:0]  ip_protocol;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [7:0]  tcp_flag_bits;
        logic [6:0]  transport_start;
        logic [7:0]  payload_start;
        logic [13:0] payload_bytes;
        logic [13:0] frame_length;
    } t_result;

    function automatic logic is_tag(input logic [15:0] et);
        return (et == EtVlan) || (et == EtQinq);
    endfunction

    function automatic logic [6:0] hdr_len(input logic [3:0] n);
        logic [6:0] h;
        h = {1'b0, n, 2'b00};
        return (h < 7'd20) ? 7'd20 : h;
    endfunction
endpackage
`default_nettype wire

[rtl/phc_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface phc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;
    modport source (output valid, frame_byte, last_byte, input ready);
    modport sink (input valid, frame_byte, last_byte, output ready);
endinterface

interface phc_out_if;
    logic              valid;
    logic              ready;
    phc_pkg::t_result  result;
    modport source (output valid, result, input ready);
    modport sink (input valid, result, output ready);
endinterface

interface phc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/phc_capture.sv]
`timescale 1ns / 1ps
`default_nettype none
module phc_capture #(
    parameter int unsigned MAX_FRAME_BYTES = phc_pkg::MaxFrameBytes
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_take,
    input  wire logic [7:0]              i_byte,
    input  wire logic                    i_last,
    output phc_pkg::t_hdr                o_hdr,
    output logic [phc_pkg::LenW-1:0]     o_len
);
    localparam int unsigned PosW = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [PosW-1:0] PosMax = PosW'(MAX_FRAME_BYTES);

    logic [PosW-1:0] r_pos, n_pos;
    phc_pkg::t_hdr r_hdr, n_hdr;
    phc_pkg::t_hdr c_hdr;
    phc_pkg::t_hdr clr_hdr;

    logic [PosW:0] pos, l3, rel, t, tp, p, pp;
    logic [15:0] et;
    logic has_tag, v4, v6, tl;

    always_comb begin
        clr_hdr = '0;
        clr_hdr.ip_hdr = 7'd20;
        clr_hdr.tcp_hdr = 7'd20;
        c_hdr = r_hdr;
        pos = {1'b0, r_pos};
        if (pos == 12) c_hdr.outer_et[15:8] = i_byte;
        if (pos == 13) c_hdr.outer_et[7:0] = i_byte;
        if (pos == 16) c_hdr.inner_et[15:8] = i_byte;
        if (pos == 17) c_hdr.inner_et[7:0] = i_byte;
        has_tag = phc_pkg::is_tag(r_hdr.outer_et);
        l3 = has_tag ? (PosW+1)'(18) : (PosW+1)'(14);
        et = has_tag ? r_hdr.inner_et : r_hdr.outer_et;
        v4 = (et == phc_pkg::EtIpv4);
        v6 = (et == phc_pkg::EtIpv6);
        rel = pos - l3;
        t = l3 + (v4 ? (PosW+1)'(r_hdr.ip_hdr) : (PosW+1)'(40));
        tp = pos - t;
        tl = (r_hdr.proto == phc_pkg::ProtoTcp) || (r_hdr.proto == phc_pkg::ProtoUdp);
        p = t + (PosW+1)'(r_hdr.tcp_hdr);
        pp = pos - p;
        if (pos >= 14 && pos >= l3 && (v4 || v6)) begin
            if (v4 && rel == 0) c_hdr.ip_hdr = phc_pkg::hdr_len(i_byte[3:0]);
            if (v4 && rel == 9) c_hdr.proto = i_byte;
            if (v6 && rel == 6) c_hdr.proto = i_byte;
            if (pos >= t && tl) begin
                if (tp == 0) c_hdr.sport[15:8] = i_byte;
                if (tp == 1) c_hdr.sport[7:0] = i_byte;
                if (tp == 2) c_hdr.dport[15:8] = i_byte;
                if (tp == 3) c_hdr.dport[7:0] = i_byte;
                if (r_hdr.proto == phc_pkg::ProtoTcp) begin
                    if (tp == 12) c_hdr.tcp_hdr = phc_pkg::hdr_len(i_byte[7:4]);
                    if (tp == 13) c_hdr.flags = i_byte;
                    if (pos >= p && pp < 7) begin
                        c_hdr.prefix = r_hdr.prefix
                            | (56'(i_byte) << (6'd48 - {pp[2:0], 3'b000}));
                    end
                end
            end
        end
        n_hdr = r_hdr;
        n_pos = r_pos;
        if (i_take) begin
            if (r_pos < PosMax) begin
                n_hdr = c_hdr;
                n_pos = r_pos + 1'b1;
            end
            if (i_last) begin
                n_hdr = clr_hdr;
                n_pos = '0;
            end
        end
        o_hdr = (r_pos < PosMax) ? c_hdr : r_hdr;
        o_len = (r_pos < PosMax) ? phc_pkg::LenW'(r_pos + 1'b1) : phc_pkg::LenW'(r_pos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_hdr <= clr_hdr;
        end else begin
            r_pos <= n_pos;
            r_hdr <= n_hdr;
        end
    end
endmodule
`default_nettype wire

[rtl/phc_classify.sv]
`timescale 1ns / 1ps
`default_nettype none
module phc_classify (
    input  wire phc_pkg::t_hdr             i_hdr,
    input  wire logic [phc_pkg::LenW-1:0]  i_len,
    input  wire phc_pkg::t_ports           i_ports,
    output phc_pkg::t_result               o_res
);
    logic [15:0] et;
    logic [7:0] l3, t, ps;
    logic [14:0] len;
    logic [1:0] kind;
    logic [13:0] pl;
    logic https_hit, http_hit, dns_hit, http_pfx;
    logic [55:0] px;

    function automatic logic hit(input logic [15:0] s, input logic [15:0] d,
                                 input logic [15:0] a);
        return (s == a) || (d == a);
    endfunction

    always_comb begin
        o_res = '0;
        len = {1'b0, i_len};
        o_res.frame_length = i_len;
        et = i_hdr.outer_et;
        l3 = 8'd14;
        t = '0;
        kind = phc_pkg::KindNone;
        ps = '0;
        pl = '0;
        px = i_hdr.prefix;
        if (len >= 14) begin
            if (phc_pkg::is_tag(et) && len >= 18) begin
                et = i_hdr.inner_et;
                l3 = 8'd18;
                o_res.vlan_tagged = 1'b1;
            end
            if (et == phc_pkg::EtIpv4 && len >= 15'(l3) + 15'd20) begin
                o_res.ip_version = 2'd1;
                o_res.ip_protocol = i_hdr.proto;
                t = l3 + 8'(i_hdr.ip_hdr);
                if (i_hdr.proto == phc_pkg::ProtoTcp && len >= 15'(t) + 15'd20)
                    kind = phc_pkg::KindTcp;
                else if (i_hdr.proto == phc_pkg::ProtoUdp && len >= 15'(t) + 15'd8)
                    kind = phc_pkg::KindUdp;
                else if (i_hdr.proto == phc_pkg::ProtoIcmp && len >= 15'(t) + 15'd8)
                    kind = phc_pkg::KindIcmp;
            end else if (et == phc_pkg::EtIpv6 && len >= 15'(l3) + 15'd40) begin
                o_res.ip_version = 2'd2;
                o_res.ip_protocol = i_hdr.proto;
                t = l3 + 8'd40;
                if (i_hdr.proto == phc_pkg::ProtoTcp && len >= 15'(t) + 15'd20)
                    kind = phc_pkg::KindTcp;
                else if (i_hdr.proto == phc_pkg::ProtoUdp && len >= 15'(t) + 15'd8)
                    kind = phc_pkg::KindUdp;
                else if (i_hdr.proto == phc_pkg::ProtoIcmp6 && len >= 15'(t) + 15'd8)
                    kind = phc_pkg::KindIcmp;
            end else if (et == phc_pkg::EtArp) begin
                o_res.protocol_class = phc_pkg::ClsArp;
            end
        end
        o_res.transport_start = t[6:0];
        if (kind != phc_pkg::KindNone) begin
            ps = t + ((kind == phc_pkg::KindTcp) ? 8'(i_hdr.tcp_hdr) : 8'd8);
            pl = (len > 15'(ps)) ? 14'(len - 15'(ps)) : 14'd0;
        end
        o_res.payload_start = ps;
        o_res.payload_bytes = pl;
        https_hit = hit(i_hdr.sport, i_hdr.dport, i_ports.https);
        http_hit = hit(i_hdr.sport, i_hdr.dport, i_ports.http)
                || hit(i_hdr.sport, i_hdr.dport, i_ports.http_alt);
        dns_hit = hit(i_hdr.sport, i_hdr.dport, i_ports.dns)
               || hit(i_hdr.sport, i_hdr.dport, i_ports.mdns);
        http_pfx = (pl >= 4) && (
            (px[55:32] == "GET") || (px[55:24] == "POST") || (px[55:32] == "PUT")
            || (pl >= 6 && px[55:8] == "DELETE") || (px[55:24] == "HEAD")
            || (pl >= 7 && px == "OPTIONS") || (px[55:24] == "HTTP"));
        unique case (kind)
            phc_pkg::KindTcp: begin
                o_res.source_port = i_hdr.sport;
                o_res.destination_port = i_hdr.dport;
                o_res.tcp_flag_bits = i_hdr.flags;
                if (https_hit) o_res.protocol_class = phc_pkg::ClsHttps;
                else if (http_hit && http_pfx) o_res.protocol_class = phc_pkg::ClsHttp;
                else o_res.protocol_class = phc_pkg::ClsTcp;
            end
            phc_pkg::KindUdp: begin
                o_res.source_port = i_hdr.sport;
                o_res.destination_port = i_hdr.dport;
                if (pl >= 12 && dns_hit) o_res.protocol_class = phc_pkg::ClsDns;
                else if (https_hit) o_res.protocol_class = phc_pkg::ClsQuic;
                else o_res.protocol_class = phc_pkg::ClsUdp;
            end
            phc_pkg::KindIcmp: o_res.protocol_class = phc_pkg::ClsIcmp;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

[rtl/packet_header_classifier_unit.sv]
// Packet header classifier.
// The input channel carries one frame byte per item, last_byte marking the
// final byte. The block accepts one item every cycle, except while it holds off a final byte.
// Each frame yields one result item, registered in the cycle after the last
// byte is accepted; no result is produced for other bytes.
// Header fields are captured on the fly by a byte-position counter; the
// classification is a single combinational pass into the result register.
// When the receiver stalls, the result register holds its item; a new item
// is still accepted if it does not complete a frame, and a final byte waits
// only while the result register is full and not being drained.
// Bytes beyond MAX_FRAME_BYTES are dropped and the length saturates.
// The configuration channel is always ready and writes five port registers.
// Synchronous reset clears frame state, empties the result register and
// restores the default ports (443, 80, 8080, 53, 5353).
`timescale 1ns / 1ps
`default_nettype none
module packet_header_classifier_unit #(
    parameter int unsigned MAX_FRAME_BYTES = phc_pkg::MaxFrameBytes
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    phc_in_if.sink     in_ch,
    phc_out_if.source  out_ch,
    phc_cfg_if.sink    cfg_ch
);
    phc_pkg::t_ports r_ports;
    phc_pkg::t_hdr hdr;
    logic [phc_pkg::LenW-1:0] len;
    phc_pkg::t_result res, r_res;
    logic r_valid, take;

    assign in_ch.ready = !(in_ch.last_byte && r_valid && !out_ch.ready);
    assign take = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = r_valid;
    assign out_ch.result = r_res;

    phc_capture #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_cap (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take),
        .i_byte(in_ch.frame_byte), .i_last(in_ch.last_byte),
        .o_hdr(hdr), .o_len(len)
    );

    phc_classify u_cls (.i_hdr(hdr), .i_len(len), .i_ports(r_ports), .o_res(res));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ports.https <= 16'd443;
            r_ports.http <= 16'd80;
            r_ports.http_alt <= 16'd8080;
            r_ports.dns <= 16'd53;
            r_ports.mdns <= 16'd5353;
        end else begin
            if (take && in_ch.last_byte) r_valid <= 1'b1;
            else if (out_ch.ready) r_valid <= 1'b0;
            if (cfg_ch.valid) begin
                unique case (cfg_ch.index)
                    phc_pkg::CfgHttps:   r_ports.https <= cfg_ch.data;
                    phc_pkg::CfgHttp:    r_ports.http <= cfg_ch.data;
                    phc_pkg::CfgHttpAlt: r_ports.http_alt <= cfg_ch.data;
                    phc_pkg::CfgDns:     r_ports.dns <= cfg_ch.data;
                    phc_pkg::CfgMdns:    r_ports.mdns <= cfg_ch.data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && in_ch.last_byte) r_res <= res;
    end

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !out_ch.ready) |-> !(take && in_ch.last_byte))
        else $error("pending result overwritten");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !out_ch.ready) |=> (r_valid && $stable(r_res)))
        else $error("stalled result changed");
    a_result_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && in_ch.last_byte) |=> r_valid)
        else $error("missing result");
`endif
endmodule
`default_nettype wire
